// ===== hdl/biquad_cascade_bandpass_filter_unit_macros.svh =====
// Assertion macros for the biquad cascade band-pass filter unit.
// Used by the port-level checker; no other dependencies.
`ifndef BIQUAD_CASCADE_BANDPASS_FILTER_UNIT_MACROS_SVH
`define BIQUAD_CASCADE_BANDPASS_FILTER_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BCBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds starting in the cycle after the antecedent.
`define BCBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bcbf_pkg.sv =====
// Shared types, widths and fixed-point coefficients for the biquad cascade.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcbf_pkg;

  localparam int STATE_FRAC_BITS = 12;
  localparam int COEF_FRAC_BITS  = 14;
  localparam int SECTIONS        = 4;

  localparam int SAMPLE_W = 10;
  localparam int OUT_W    = 12;
  localparam int DATA_W   = 32;
  localparam int COEF_W   = COEF_FRAC_BITS + 2;
  localparam int PROD_W   = DATA_W + COEF_W;
  localparam int ACC_W    = PROD_W + 2;

  localparam longint E8_SCALE = 100000000;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // Per-section setup handed to each cell.
  typedef struct packed {
    coef_t na1;      // negated first feedback coefficient
    coef_t na2;      // negated second feedback coefficient
    logic  lowpass;  // feed-forward through coefficient products
    logic  tap_neg;  // integer middle tap is -2 rather than +2
  } cell_cfg_t;

  // Coefficients in units of 1e-8.
  localparam longint FB_FIRST_E8 [SECTIONS] = '{
    64'sd5159732, -64'sd53945795, 64'sd47319594, -64'sd100211112
  };
  localparam longint FB_SECOND_E8 [SECTIONS] = '{
    64'sd36347401, 64'sd39764934, 64'sd70744137, 64'sd74520226
  };
  localparam longint LP_B0_E8 = 64'sd1856301;
  localparam longint LP_B1_E8 = 64'sd3712602;

  // Scale to COEF_FRAC_BITS, rounding half away from zero.
  function automatic coef_t to_coef(input longint e8);
    longint mag;
    mag = (e8 < 0) ? -e8 : e8;
    mag = ((mag <<< COEF_FRAC_BITS) + E8_SCALE / 2) / E8_SCALE;
    return coef_t'((e8 < 0) ? -mag : mag);
  endfunction

  localparam coef_t LP_B0 = to_coef(LP_B0_E8);
  localparam coef_t LP_B1 = to_coef(LP_B1_E8);

  function automatic cell_cfg_t section_cfg(input int k);
    cell_cfg_t c;
    c.na1     = to_coef(-FB_FIRST_E8[k]);
    c.na2     = to_coef(-FB_SECOND_E8[k]);
    c.lowpass = (k == 0);
    c.tap_neg = (k != 2);
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/biquad_cascade_bandpass_filter_unit.sv =====
// Band-pass filter unit: a row of four biquad cells and an output register.
// Depends on bcbf_pkg and bcbf_cell.
//
// Usage:
//   Input channel in_valid / in_ready / in_sample carries one unsigned
//   10-bit sample per beat. Output channel out_valid / out_ready /
//   out_filtered carries one 12-bit signed filtered sample per input.
//   Each cell runs one section on its own multiplier and hands its result
//   to the next cell, so up to four samples are in the row at once.
//   Throughput is set by the first (low-pass) section, which sequences
//   five products through its multiplier; the other sections need two
//   products each. A cell takes a new sample only once it has handed on
//   its last result to the next stage.
//   Reset (rst_n low, synchronous) clears all section delays to zero and
//   empties the row. When the receiver stalls, out_filtered holds in the
//   output register; the cells behind it fill up and then in_ready drops
//   until the result is taken.
`default_nettype none

module biquad_cascade_bandpass_filter_unit import bcbf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_W-1:0]        in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    out_filtered
);

  typedef logic signed [DATA_W:0] ext_t;

  localparam ext_t OUT_MAX  = ext_t'((1 <<< (OUT_W - 1)) - 1);
  localparam ext_t OUT_MIN  = -ext_t'(1 <<< (OUT_W - 1));
  localparam ext_t TRUNC_BIAS = ext_t'((1 <<< STATE_FRAC_BITS) - 1);

  logic  vld [SECTIONS+1];
  logic  rdy [SECTIONS+1];
  data_t dat [SECTIONS+1];

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_filtered_r;
  ext_t                    y_ext;
  ext_t                    t_nxt;
  logic signed [OUT_W-1:0] filtered_nxt;

  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];
  assign dat[0]   = {{(DATA_W-SAMPLE_W-STATE_FRAC_BITS){1'b0}}, in_sample,
                     {STATE_FRAC_BITS{1'b0}}};

  for (genvar k = 0; k < SECTIONS; k++) begin : g_cell
    bcbf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (section_cfg(k)),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_x      (dat[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_y     (dat[k+1])
    );
  end

  assign rdy[SECTIONS] = !out_valid_r || out_ready;

  // Truncate toward zero: bias negative values before the shift.
  assign y_ext = ext_t'(dat[SECTIONS]);
  assign t_nxt = (y_ext + (y_ext[DATA_W] ? TRUNC_BIAS : ext_t'(0))) >>> STATE_FRAC_BITS;

  always_comb begin
    priority if (t_nxt > OUT_MAX) begin
      filtered_nxt = OUT_MAX[OUT_W-1:0];
    end else if (t_nxt < OUT_MIN) begin
      filtered_nxt = OUT_MIN[OUT_W-1:0];
    end else begin
      filtered_nxt = t_nxt[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (vld[SECTIONS] && rdy[SECTIONS]) begin
        out_valid_r    <= 1'b1;
        out_filtered_r <= filtered_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

endmodule

`default_nettype wire

// ===== hdl/bcbf_cell.sv =====
// One direct-form-II biquad section with its two delay registers.
// Depends on bcbf_pkg; one shared multiplier sequenced over the products.
`default_nettype none

module bcbf_cell import bcbf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cfg_t cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  data_t     in_x,
  output logic      out_valid,
  input  logic      out_ready,
  output data_t     out_y
);

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FB1, S_FB2, S_FBW, S_LP1, S_LP2, S_LP3, S_LPY, S_TAP, S_DONE
  } state_t;

  localparam data_t D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t D_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam acc_t  HALF  = acc_t'(1) <<< (COEF_FRAC_BITS - 1);

  function automatic data_t sat_data(input acc_t v);
    if (v > acc_t'(D_MAX)) begin
      return D_MAX;
    end
    if (v < acc_t'(D_MIN)) begin
      return D_MIN;
    end
    return data_t'(v);
  endfunction

  state_t state_r;
  data_t  z1_r, z2_r, x_r, w_r, y_r;
  acc_t   acc_r;
  prod_t  prod_r;

  data_t  mul_a;
  coef_t  mul_c;
  prod_t  prod_nxt;
  acc_t   acc_nxt;
  acc_t   rnd;
  data_t  rnd_nxt;
  acc_t   z1x2;
  acc_t   tap_sum;
  data_t  tap_nxt;

  // Pick the operands of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_c = '0;
    unique case (state_r)
      S_FB1: begin mul_a = z1_r; mul_c = cfg.na1; end
      S_FB2: begin mul_a = z2_r; mul_c = cfg.na2; end
      S_LP1: begin mul_a = w_r;  mul_c = LP_B0;   end
      S_LP2: begin mul_a = z1_r; mul_c = LP_B1;   end
      S_LP3: begin mul_a = z2_r; mul_c = LP_B0;   end
      default: begin mul_a = '0; mul_c = '0; end
    endcase
  end

  assign prod_nxt = prod_t'(mul_a) * prod_t'(mul_c);
  assign acc_nxt  = acc_r + acc_t'(prod_r);
  // Round half up, then clamp to the signal range.
  assign rnd      = (acc_nxt + HALF) >>> COEF_FRAC_BITS;
  assign rnd_nxt  = sat_data(rnd);

  assign z1x2     = acc_t'(z1_r) <<< 1;
  assign tap_sum  = acc_t'(w_r) + acc_t'(z2_r) + (cfg.tap_neg ? -z1x2 : z1x2);
  assign tap_nxt  = sat_data(tap_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      z1_r    <= '0;
      z2_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r     <= in_x;
            state_r <= S_FB1;
          end
        end
        S_FB1: begin
          acc_r   <= acc_t'(x_r) <<< COEF_FRAC_BITS;
          prod_r  <= prod_nxt;
          state_r <= S_FB2;
        end
        S_FB2: begin
          acc_r   <= acc_nxt;
          prod_r  <= prod_nxt;
          state_r <= S_FBW;
        end
        S_FBW: begin
          w_r     <= rnd_nxt;
          state_r <= cfg.lowpass ? S_LP1 : S_TAP;
        end
        S_LP1: begin
          acc_r   <= '0;
          prod_r  <= prod_nxt;
          state_r <= S_LP2;
        end
        S_LP2: begin
          acc_r   <= acc_nxt;
          prod_r  <= prod_nxt;
          state_r <= S_LP3;
        end
        S_LP3: begin
          acc_r   <= acc_nxt;
          prod_r  <= prod_nxt;
          state_r <= S_LPY;
        end
        S_LPY: begin
          y_r     <= rnd_nxt;
          z2_r    <= z1_r;
          z1_r    <= w_r;
          state_r <= S_DONE;
        end
        S_TAP: begin
          y_r     <= tap_nxt;
          z2_r    <= z1_r;
          z1_r    <= w_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the next section takes the beat.
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_y     = y_r;

endmodule

`default_nettype wire

// ===== hdl/bcbf_checker.sv =====
// Port-level checker for the band-pass filter unit, bound to the top level.
// Depends on bcbf_pkg and the assertion macro header.
`default_nettype none
`include "biquad_cascade_bandpass_filter_unit_macros.svh"

module bcbf_checker import bcbf_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [OUT_W-1:0] out_filtered
);

  localparam logic [2:0] PEND_MAX = 3'(SECTIONS + 1);

  logic [2:0] pending_r;
  logic [2:0] pending_nxt;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Track samples taken but not yet delivered.
  always_comb begin
    pending_nxt = pending_r;
    if (in_beat && !out_beat) begin
      pending_nxt = pending_r + 3'd1;
    end else if (out_beat && !in_beat) begin
      pending_nxt = pending_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `BCBF_ASSERT_NEXT(a_in_busy, clk, rst_n, in_beat, !in_ready ##1 !in_ready ##1 !in_ready, "input accepted again while the first section is busy")
  `BCBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_filtered), "stalled result changed")
  `BCBF_ASSERT_NOW(a_no_spurious, clk, rst_n, out_valid, pending_r != 3'd0, "result shown with no sample in flight")
  `BCBF_ASSERT_NOW(a_pend_bound, clk, rst_n, in_ready, pending_r < PEND_MAX, "more samples in flight than the row can hold")

endmodule

bind biquad_cascade_bandpass_filter_unit bcbf_checker u_bcbf_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for biquad_cascade_bandpass_filter_unit.
// Depends on bcbf_pkg and the RTL. A scoreboard class predicts each filtered
// sample in fixed point, and random valid/ready gaps are applied on both channels.

import bcbf_pkg::*;

class bandpass_tracker;

  longint fb_first[SECTIONS];
  longint fb_second[SECTIONS];
  longint mid_tap[SECTIONS];
  longint lp_b0;
  longint lp_b1;
  data_t  delay_one[SECTIONS];
  data_t  delay_two[SECTIONS];
  logic signed [OUT_W-1:0] filtered_due[$];
  int     errors;

  function new();
    fb_first  = '{quantize(5159732), quantize(-53945795), quantize(47319594),
                  quantize(-100211112)};
    fb_second = '{quantize(36347401), quantize(39764934), quantize(70744137),
                  quantize(74520226)};
    mid_tap   = '{0, -2, 2, -2};
    lp_b0     = quantize(1856301);
    lp_b1     = quantize(3712602);
    foreach (delay_one[k]) begin
      delay_one[k] = '0;
      delay_two[k] = '0;
    end
    errors = 0;
  endfunction

  // Scale a value in units of 1e-8 to the coefficient format, half away from zero.
  function longint quantize(longint e8);
    longint mag;
    mag = (e8 < 0) ? -e8 : e8;
    mag = ((mag <<< COEF_FRAC_BITS) + 64'sd50000000) / 64'sd100000000;
    return (e8 < 0) ? -mag : mag;
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Drop the coefficient fraction, rounding half up.
  function longint drop_coef_frac(longint v);
    return (v + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  endfunction

  function logic signed [OUT_W-1:0] filter_sample(logic [SAMPLE_W-1:0] sample);
    longint x;
    longint acc;
    longint w;
    longint y;
    longint t;
    x = longint'(sample);
    x = x <<< STATE_FRAC_BITS;
    for (int k = 0; k < SECTIONS; k++) begin
      acc = (x <<< COEF_FRAC_BITS) - fb_first[k] * delay_one[k]
            - fb_second[k] * delay_two[k];
      w = clip32(drop_coef_frac(acc));
      if (k == 0) begin
        y = clip32(drop_coef_frac(lp_b0 * w + lp_b1 * delay_one[k]
                                  + lp_b0 * delay_two[k]));
      end else begin
        y = clip32(w + mid_tap[k] * delay_one[k] + delay_two[k]);
      end
      delay_two[k] = delay_one[k];
      delay_one[k] = data_t'(w);
      x = y;
    end
    // Truncate toward zero, then clamp to the output range.
    t = (x >= 0) ? (x >>> STATE_FRAC_BITS) : -((-x) >>> STATE_FRAC_BITS);
    if (t > 2047) t = 2047;
    if (t < -2048) t = -2048;
    return t[OUT_W-1:0];
  endfunction

  function void take_sample(logic [SAMPLE_W-1:0] sample);
    filtered_due.push_back(filter_sample(sample));
  endfunction

  function void check_filtered(logic signed [OUT_W-1:0] actual);
    logic signed [OUT_W-1:0] want;
    if (filtered_due.size() == 0) begin
      $display("%0t: filtered beat %0d with no sample pending", $time, actual);
      errors++;
      return;
    end
    want = filtered_due.pop_front();
    if (actual !== want) begin
      $display("%0t: filtered mismatch: expected %0d actual %0d", $time, want, actual);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bcbf_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASE_ITEMS = 350;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     in_sample;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] out_filtered;

  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  bandpass_tracker tracker = new();

  biquad_cascade_bandpass_filter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_filtered(out_filtered)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_filtered(out_filtered);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL biquad_cascade_bandpass_filter_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_sample(sample);
  endtask

  task automatic send_level(input logic [SAMPLE_W-1:0] sample, input int count);
    repeat (count) send_sample(sample);
  endtask

  // Bursts of square waves, ramps, steps and noise with random content.
  task automatic send_random(input int count);
    int sent;
    int kind;
    int len;
    int period;
    int lo;
    int hi;
    logic [SAMPLE_W-1:0] value;
    sent = 0;
    while (sent < count) begin
      kind   = $urandom_range(4);
      len    = $urandom_range(40, 8);
      period = $urandom_range(40, 2);
      lo     = $urandom_range(1023);
      hi     = $urandom_range(1023);
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: value = 10'($urandom_range(1023));
          1: value = (((i / ((period + 1) / 2)) % 2) != 0) ? hi[9:0] : lo[9:0];
          2: value = (((i / ((period + 1) / 2)) % 2) != 0) ? 10'd1023 : 10'd0;
          3: value = 10'(lo + i * period);
          default: value = (i < len / 2) ? lo[9:0] : hi[9:0];
        endcase
        send_sample(value);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample      = '0;
    out_ready      = 1'b0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: floor, full-scale step, release, Nyquist toggling, odd values.
    send_level(10'd0, 3);
    send_level(10'd1023, 6);
    send_level(10'd0, 4);
    repeat (3) begin
      send_sample(10'd1023);
      send_sample(10'd0);
    end
    send_sample(10'd512);
    send_sample(10'd1);
    send_sample(10'd1022);
    send_sample(10'd341);
    send_sample(10'd682);

    send_random(PHASE_ITEMS);
    send_idle_pct  = 50;
    send_random(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    send_random(PHASE_ITEMS);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    send_random(PHASE_ITEMS);
    in_valid <= 1'b0;

    while (tracker.filtered_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS biquad_cascade_bandpass_filter_unit");
    end else begin
      $display("FAIL biquad_cascade_bandpass_filter_unit");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bcbf_pkg.sv
hdl/bcbf_cell.sv
hdl/biquad_cascade_bandpass_filter_unit.sv
hdl/bcbf_checker.sv
verif/testbench.sv
